// ===== hdl/adsr_envelope_gain_macros.svh =====
// Assertion macros for the ADSR envelope gain block
`ifndef ADSR_ENVELOPE_GAIN_MACROS_SVH
`define ADSR_ENVELOPE_GAIN_MACROS_SVH

// Checked only out of reset
`define AEG_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every edge, reset included
`define AEG_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== hdl/aeg_pkg.sv =====
// Shared constants and types for the ADSR envelope gain block
`timescale 1ns / 1ps

package aeg_pkg;

  localparam int unsigned LEVEL_W   = 16;
  localparam int unsigned QUO_W     = 16;
  localparam int unsigned GAIN_FRAC = 15;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [LEVEL_W-1:0] UNITY_GAIN = 16'h8000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ATTACK_LEN    = 3'd0,
    CFG_ATTACK_LEVEL  = 3'd1,
    CFG_DECAY_LEN     = 3'd2,
    CFG_SUSTAIN_LEVEL = 3'd3,
    CFG_RELEASE_LEN   = 3'd4,
    CFG_NOTE_LEN      = 3'd5
  } cfg_reg_e;

  function automatic logic [LEVEL_W-1:0] clamp_level(input logic [LEVEL_W-1:0] v);
    clamp_level = (v > UNITY_GAIN) ? UNITY_GAIN : v;
  endfunction

endpackage

// ===== hdl/adsr_envelope_gain.sv =====
// Ramp samples pass through load, multiply, a 16-step divide, gain, scale and output;
// sustain and past-end samples skip the divide. The back end takes one sample at a time
// (ramps share the 16-step restoring divider) and loads the next only after the last
// enters the output register, once that is free or popped. A two-entry queue buffers
// the front end. Reset: asynchronous; clears the sample index, the queue and the output
// valid flag, and returns lengths to 0, levels to unity and the note length to 1.
`timescale 1ns / 1ps

module adsr_envelope_gain #(
  parameter int unsigned COUNT_WIDTH  = 24,
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push,
  output logic                             full,
  input  logic signed [SAMPLE_WIDTH-1:0]   sample_in_i,
  input  logic                             start_req_i,
  output logic                             empty,
  input  logic                             pop,
  output logic signed [SAMPLE_WIDTH-1:0]   sample_out_o,
  output logic [aeg_pkg::LEVEL_W-1:0]      gain_o,
  output logic                             last_o,
  output logic                             past_end_o,
  input  logic                             cfg_we_i,
  input  logic [aeg_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [COUNT_WIDTH:0]             cfg_wdata_i
);

  localparam int unsigned LW      = aeg_pkg::LEVEL_W;
  localparam int unsigned ENTRY_W = SAMPLE_WIDTH + 4 + 2 * LW + 2 * COUNT_WIDTH;

  logic [COUNT_WIDTH-1:0] attack_len_q, decay_len_q, release_len_q;
  logic [LW-1:0]          attack_level_q, sustain_level_q;
  logic [COUNT_WIDTH:0]   note_len_q;

  logic               q_push, q_full, q_pop, q_empty;
  logic [ENTRY_W-1:0] q_wdata, q_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_len_q    <= '0;
      attack_level_q  <= aeg_pkg::UNITY_GAIN;
      decay_len_q     <= '0;
      sustain_level_q <= aeg_pkg::UNITY_GAIN;
      release_len_q   <= '0;
      note_len_q      <= (COUNT_WIDTH + 1)'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        aeg_pkg::CFG_ATTACK_LEN:    attack_len_q    <= cfg_wdata_i[COUNT_WIDTH-1:0];
        aeg_pkg::CFG_ATTACK_LEVEL:  attack_level_q  <= cfg_wdata_i[LW-1:0];
        aeg_pkg::CFG_DECAY_LEN:     decay_len_q     <= cfg_wdata_i[COUNT_WIDTH-1:0];
        aeg_pkg::CFG_SUSTAIN_LEVEL: sustain_level_q <= cfg_wdata_i[LW-1:0];
        aeg_pkg::CFG_RELEASE_LEN:   release_len_q   <= cfg_wdata_i[COUNT_WIDTH-1:0];
        aeg_pkg::CFG_NOTE_LEN:      note_len_q      <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  aeg_front #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .ENTRY_W     (ENTRY_W)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .sample_in_i    (sample_in_i),
    .start_req_i    (start_req_i),
    .attack_len_i   (attack_len_q),
    .attack_level_i (attack_level_q),
    .decay_len_i    (decay_len_q),
    .sustain_level_i(sustain_level_q),
    .release_len_i  (release_len_q),
    .note_len_i     (note_len_q),
    .q_push_o       (q_push),
    .q_data_o       (q_wdata),
    .q_full_i       (q_full)
  );

  aeg_queue #(
    .WIDTH(ENTRY_W)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_wdata),
    .full_o (q_full),
    .pop_i  (q_pop),
    .data_o (q_rdata),
    .empty_o(q_empty)
  );

  aeg_back #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .ENTRY_W     (ENTRY_W)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_data_i    (q_rdata),
    .q_empty_i   (q_empty),
    .q_pop_o     (q_pop),
    .empty       (empty),
    .pop         (pop),
    .sample_out_o(sample_out_o),
    .gain_o      (gain_o),
    .last_o      (last_o),
    .past_end_o  (past_end_o)
  );

endmodule

// ===== hdl/aeg_front.sv =====
// Front end: sample index tracking and envelope phase classification
`timescale 1ns / 1ps

module aeg_front #(
  parameter int unsigned COUNT_WIDTH  = 24,
  parameter int unsigned SAMPLE_WIDTH = 16,
  parameter int unsigned ENTRY_W      = SAMPLE_WIDTH + 4 + 2 * aeg_pkg::LEVEL_W
                                        + 2 * COUNT_WIDTH
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push,
  output logic                                full,
  input  logic signed [SAMPLE_WIDTH-1:0]      sample_in_i,
  input  logic                                start_req_i,
  input  logic [COUNT_WIDTH-1:0]              attack_len_i,
  input  logic [aeg_pkg::LEVEL_W-1:0]         attack_level_i,
  input  logic [COUNT_WIDTH-1:0]              decay_len_i,
  input  logic [aeg_pkg::LEVEL_W-1:0]         sustain_level_i,
  input  logic [COUNT_WIDTH-1:0]              release_len_i,
  input  logic [COUNT_WIDTH:0]                note_len_i,
  output logic                                q_push_o,
  output logic [ENTRY_W-1:0]                  q_data_o,
  input  logic                                q_full_i
);

  localparam int unsigned IW = COUNT_WIDTH + 1;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic                           last;
    logic                           past_end;
    logic                           use_div;
    logic                           sub;
    logic [aeg_pkg::LEVEL_W-1:0]    base;
    logic [aeg_pkg::LEVEL_W-1:0]    mul_a;
    logic [COUNT_WIDTH-1:0]         mul_b;
    logic [COUNT_WIDTH-1:0]         divisor;
  } entry_t;

  logic [IW-1:0]               idx_q, idx_d;
  logic [IW-1:0]               cur;
  logic                        accept;
  logic                        past, in_rel, in_att, in_dec;
  logic [IW:0]                 rel_sum;
  logic [IW-1:0]               dec_end;
  logic [aeg_pkg::LEVEL_W-1:0] al, sl;
  entry_t                      ent;

  assign accept   = push && !q_full_i;
  assign full     = q_full_i;
  assign q_push_o = accept;

  assign cur   = start_req_i ? '0 : idx_q;
  assign idx_d = (cur != {IW{1'b1}}) ? cur + IW'(1) : cur;

  assign al = aeg_pkg::clamp_level(attack_level_i);
  assign sl = aeg_pkg::clamp_level(sustain_level_i);

  assign past    = cur >= note_len_i;
  assign rel_sum = {1'b0, cur} + {2'b00, release_len_i};
  assign in_rel  = (release_len_i != '0) && (rel_sum >= {1'b0, note_len_i}) && !past;
  assign in_att  = cur < {1'b0, attack_len_i};
  assign dec_end = {1'b0, attack_len_i} + {1'b0, decay_len_i};
  assign in_dec  = cur < dec_end;

  always_comb begin
    ent          = '0;
    ent.sample   = sample_in_i;
    ent.past_end = past;
    ent.last     = !past && (cur == note_len_i - IW'(1));
    if (past) begin
      ent.base = '0;
    end else if (in_rel) begin
      ent.use_div = 1'b1;
      ent.mul_a   = sl;
      ent.mul_b   = COUNT_WIDTH'(note_len_i - IW'(1) - cur);
      ent.divisor = release_len_i;
    end else if (in_att) begin
      ent.use_div = 1'b1;
      ent.mul_a   = al;
      ent.mul_b   = cur[COUNT_WIDTH-1:0];
      ent.divisor = attack_len_i;
    end else if (in_dec) begin
      ent.use_div = 1'b1;
      ent.base    = al;
      ent.sub     = sl < al;
      ent.mul_a   = (sl < al) ? al - sl : sl - al;
      ent.mul_b   = COUNT_WIDTH'(cur - {1'b0, attack_len_i});
      ent.divisor = decay_len_i;
    end else begin
      ent.base = sl;
    end
  end

  assign q_data_o = ent;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (accept) begin
      idx_q <= idx_d;
    end
  end

endmodule

// ===== hdl/aeg_queue.sv =====
// Two-entry queue between front and back end
`timescale 1ns / 1ps

module aeg_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned DEPTH = 2;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       count_q;
  logic             do_push, do_pop;

  assign full_o  = count_q == 2'(DEPTH);
  assign empty_o = count_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= !wr_ptr_q;
      if (do_pop)  rd_ptr_q <= !rd_ptr_q;
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// ===== hdl/aeg_back.sv =====
// Back end: ramp multiply, 16-step divider, gain apply and output register
`timescale 1ns / 1ps

module aeg_back #(
  parameter int unsigned COUNT_WIDTH  = 24,
  parameter int unsigned SAMPLE_WIDTH = 16,
  parameter int unsigned ENTRY_W      = SAMPLE_WIDTH + 4 + 2 * aeg_pkg::LEVEL_W
                                        + 2 * COUNT_WIDTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [ENTRY_W-1:0]             q_data_i,
  input  logic                           q_empty_i,
  output logic                           q_pop_o,
  output logic                           empty,
  input  logic                           pop,
  output logic signed [SAMPLE_WIDTH-1:0] sample_out_o,
  output logic [aeg_pkg::LEVEL_W-1:0]    gain_o,
  output logic                           last_o,
  output logic                           past_end_o
);

  localparam int unsigned LW    = aeg_pkg::LEVEL_W;
  localparam int unsigned QW    = aeg_pkg::QUO_W;
  localparam int unsigned CNT_W = $clog2(QW);
  localparam int unsigned PW    = SAMPLE_WIDTH + LW + 1;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic                           last;
    logic                           past_end;
    logic                           use_div;
    logic                           sub;
    logic [LW-1:0]                  base;
    logic [LW-1:0]                  mul_a;
    logic [COUNT_WIDTH-1:0]         mul_b;
    logic [COUNT_WIDTH-1:0]         divisor;
  } entry_t;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_MUL   = 6'b000010,
    ST_DIV   = 6'b000100,
    ST_GAIN  = 6'b001000,
    ST_SCALE = 6'b010000,
    ST_DONE  = 6'b100000
  } state_e;

  state_e                 state_q, state_d;
  entry_t                 ent_q;
  logic [COUNT_WIDTH-1:0] rem_q;
  logic [QW-1:0]          quo_q;
  logic [CNT_W-1:0]       cnt_q;
  logic [LW-1:0]          gain_q;
  logic signed [PW-1:0]   prod_q;
  logic                   out_valid_q;

  logic [LW+COUNT_WIDTH-1:0] ramp_prod;
  logic [COUNT_WIDTH:0]      trial;
  logic                      quo_bit;
  logic                      load_out;

  assign ramp_prod = ent_q.mul_a * ent_q.mul_b;
  assign trial     = {rem_q, quo_q[QW-1]} - {1'b0, ent_q.divisor};
  assign quo_bit   = !trial[COUNT_WIDTH];
  assign load_out  = (state_q == ST_DONE) && (!out_valid_q || pop);
  assign q_pop_o   = (state_q == ST_IDLE) && !q_empty_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (!q_empty_i) state_d = ST_MUL;
      ST_MUL:   state_d = ent_q.use_div ? ST_DIV : ST_GAIN;
      ST_DIV:   if (cnt_q == CNT_W'(QW - 1)) state_d = ST_GAIN;
      ST_GAIN:  state_d = ST_SCALE;
      ST_SCALE: state_d = ST_DONE;
      ST_DONE:  if (load_out) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      ent_q <= q_data_i;
    end
    if (state_q == ST_MUL) begin
      rem_q <= ramp_prod[LW+COUNT_WIDTH-1:QW];
      quo_q <= ramp_prod[QW-1:0];
      cnt_q <= '0;
    end
    if (state_q == ST_DIV) begin
      rem_q <= quo_bit ? trial[COUNT_WIDTH-1:0] : {rem_q[COUNT_WIDTH-2:0], quo_q[QW-1]};
      quo_q <= {quo_q[QW-2:0], quo_bit};
      cnt_q <= cnt_q + CNT_W'(1);
    end
    if (state_q == ST_GAIN) begin
      if (!ent_q.use_div) begin
        gain_q <= ent_q.base;
      end else if (ent_q.sub) begin
        gain_q <= ent_q.base - quo_q;
      end else begin
        gain_q <= ent_q.base + quo_q;
      end
    end
    if (state_q == ST_SCALE) begin
      prod_q <= ent_q.sample * $signed({1'b0, gain_q});
    end
    if (load_out) begin
      sample_out_o <= prod_q[aeg_pkg::GAIN_FRAC +: SAMPLE_WIDTH];
      gain_o       <= gain_q;
      last_o       <= ent_q.last;
      past_end_o   <= ent_q.past_end;
    end
  end

  assign empty = !out_valid_q;

endmodule

// ===== hdl/aeg_checker.sv =====
// Port-level checks for the ADSR envelope gain block, bound to the top level
`timescale 1ns / 1ps
`include "adsr_envelope_gain_macros.svh"

module aeg_checker #(
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             empty,
  input logic                             pop,
  input logic signed [SAMPLE_WIDTH-1:0]   sample_out_o,
  input logic [aeg_pkg::LEVEL_W-1:0]      gain_o,
  input logic                             last_o,
  input logic                             past_end_o
);

  `AEG_ASSERT_ALWAYS(a_reset_empty, !rst_ni |-> empty, "result queue not empty in reset")
  `AEG_ASSERT(a_gain_range, !empty |-> gain_o <= aeg_pkg::UNITY_GAIN, "gain above unity")
  `AEG_ASSERT(a_past_end_zero, (!empty && past_end_o) |-> (gain_o == '0 && !last_o),
              "past-end transaction carries gain or last")
  `AEG_ASSERT(a_zero_gain_silent, (!empty && gain_o == '0) |-> sample_out_o == '0,
              "nonzero sample with zero gain")
  `AEG_ASSERT(a_result_held, (!empty && !pop) |=> (!empty && $stable(sample_out_o)
              && $stable(gain_o) && $stable(last_o) && $stable(past_end_o)),
              "waiting transaction changed")

endmodule

bind adsr_envelope_gain aeg_checker #(
  .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_aeg_checker (.*);
